// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the prefetch tracking table RTL.
// Uses the clk and arst_n names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle property, off during reset.
`define PTT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ptt: assertion failed");
// Condition in one cycle implies a property in the next.
`define PTT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ptt: next-cycle assertion failed");
`else
`define PTT_ASSERT(lbl, prop)
`define PTT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/ptt_pkg.sv =====
// Package for the prefetch tracking table: payload structs, op and outcome codes,
// register map and sizing constants. No dependencies.
`default_nettype none

package ptt_pkg;

	localparam int ADDR_W        = 48;
	localparam int CNT_W         = 32;
	localparam int LSZ_W         = 4;
	localparam int OP_W          = 3;
	localparam int TABLE_ENTRIES_DEF = 16;

	localparam logic [LSZ_W-1:0] LSZ_MIN   = 4'd2;
	localparam logic [LSZ_W-1:0] LSZ_MAX   = 4'd12;
	localparam logic [LSZ_W-1:0] LSZ_RESET = 4'd6;

	// APB map: one 32-bit register per word
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_LINE_SIZE = 1'b0;

	localparam logic [OP_W-1:0] OP_PREFETCH = 3'd0;
	localparam logic [OP_W-1:0] OP_READ     = 3'd1;
	localparam logic [OP_W-1:0] OP_WRITE    = 3'd2;
	localparam logic [OP_W-1:0] OP_EVICT    = 3'd3;
	localparam logic [OP_W-1:0] OP_OTHER    = 3'd4;

	typedef enum logic [2:0] {
		OUT_NONE    = 3'd0,
		OUT_ISSUED  = 3'd1,
		OUT_USED    = 3'd2,
		OUT_LATE    = 3'd3,
		OUT_UNUSED  = 3'd4,
		OUT_DROPPED = 3'd5
	} outcome_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic              hit;
	} req_t;

	typedef struct packed {
		logic              issue_valid;
		logic [ADDR_W-1:0] issue_addr;
		outcome_t          outcome;
		logic [CNT_W-1:0]  issued_count;
		logic [CNT_W-1:0]  used_count;
		logic [CNT_W-1:0]  unused_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hdl/prefetch_tracking_table_core.sv =====
// Prefetch tracking table: fully associative table of outstanding prefetched lines,
// usefulness counters and APB line-size register. Depends on ptt_pkg, assert_macros.svh.
//
//  channel | direction | signals                         | accepted when
//  --------+-----------+---------------------------------+-------------------------------
//  req     | in        | req_valid, req_stall, req       | req_valid & !req_stall
//  rsp     | out       | rsp_valid, rsp_stall, rsp       | rsp_valid & !rsp_stall
//  apb     | in        | psel, penable, pwrite, paddr... | psel & penable & pwrite & pready
//
// One item per cycle while rsp_stall is low; path: input register, then result register.
// The lookup, insert/remove and counter update sit between those two registers; the
// table and counters are written at the edge the result register loads, so the next
// item always sees the previous one's effect.
// Reset clears the valid bits and counters at once; no clearing pass is needed.
// A stalled result holds the input register; req_stall rises only while it is full.
`default_nettype none
`include "assert_macros.svh"

module prefetch_tracking_table_core
	import ptt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// config port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready,
	// request channel
	input  wire logic               req_valid,
	output      logic               req_stall,
	input  wire req_t               req,
	// result channel
	output      logic               rsp_valid,
	input  wire logic               rsp_stall,
	output      rsp_t               rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// ---------------------------------------------------------------- config
	logic [LSZ_W-1:0] lsz_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_LINE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsz_q <= LSZ_RESET;
		end else if (cfg_wr) begin
			lsz_q <= pwdata[LSZ_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_LINE_SIZE) begin
			prdata = PDATA_W'(lsz_q);
		end
	end

	// ---------------------------------------------------------------- handshake
	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic adv;       // s1 item moves into the result register
	logic take;      // new item enters s1

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign take      = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
	end

	// ---------------------------------------------------------------- table state
	logic [TABLE_ENTRIES-1:0] entry_valid_q;
	logic [ADDR_W-1:0]        entry_addr_q [TABLE_ENTRIES];
	logic [CNT_W-1:0]         issued_q;
	logic [CNT_W-1:0]         used_q;
	logic [CNT_W-1:0]         unused_q;

	// ---------------------------------------------------------------- lookup
	logic [LSZ_W-1:0]         lsz_eff;
	logic [ADDR_W-1:0]        line_mask;
	logic [ADDR_W-1:0]        line;
	logic [TABLE_ENTRIES-1:0] match;
	logic                     found;
	logic [IDX_W-1:0]         match_idx;
	logic                     has_free;
	logic [IDX_W-1:0]         free_idx;

	// clamp line size to the supported range
	always_comb begin
		priority if (lsz_q < LSZ_MIN) begin
			lsz_eff = LSZ_MIN;
		end else if (lsz_q > LSZ_MAX) begin
			lsz_eff = LSZ_MAX;
		end else begin
			lsz_eff = lsz_q;
		end
	end

	always_comb begin
		for (int b = 0; b < ADDR_W; b++) begin
			line_mask[b] = (b >= int'(lsz_eff));
		end
	end

	assign line = req_s1.addr & line_mask;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match[i] = entry_valid_q[i] && (entry_addr_q[i] == line);
		end
	end

	// lowest-numbered match and lowest-numbered free slot
	always_comb begin
		found     = 1'b0;
		match_idx = '0;
		has_free  = 1'b0;
		free_idx  = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				found     = 1'b1;
				match_idx = IDX_W'(i);
			end
			if (!entry_valid_q[i]) begin
				has_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// ---------------------------------------------------------------- decision
	logic             set_en;
	logic             clr_en;
	logic             inc_issued;
	logic             inc_used;
	logic             inc_unused;
	outcome_t         outcome;
	logic [CNT_W-1:0] issued_nx;
	logic [CNT_W-1:0] used_nx;
	logic [CNT_W-1:0] unused_nx;

	always_comb begin
		set_en     = 1'b0;
		clr_en     = 1'b0;
		inc_issued = 1'b0;
		inc_used   = 1'b0;
		inc_unused = 1'b0;
		outcome    = OUT_NONE;
		unique case (req_s1.op)
			OP_PREFETCH: begin
				if (!found) begin
					if (has_free) begin
						set_en     = 1'b1;
						inc_issued = 1'b1;
						outcome    = OUT_ISSUED;
					end else begin
						outcome = OUT_DROPPED;
					end
				end
			end
			OP_READ, OP_WRITE: begin
				if (found) begin
					clr_en = 1'b1;
					if (req_s1.hit) begin
						inc_used = 1'b1;
						outcome  = OUT_USED;
					end else begin
						outcome = OUT_LATE;
					end
				end
			end
			OP_EVICT: begin
				if (found) begin
					clr_en     = 1'b1;
					inc_unused = 1'b1;
					outcome    = OUT_UNUSED;
				end
			end
			default: begin
				// other accesses and unused codes leave everything alone
			end
		endcase
	end

	// saturating counters
	assign issued_nx = (inc_issued && issued_q != '1) ? issued_q + 1'b1 : issued_q;
	assign used_nx   = (inc_used   && used_q   != '1) ? used_q   + 1'b1 : used_q;
	assign unused_nx = (inc_unused && unused_q != '1) ? unused_q + 1'b1 : unused_q;

	// ---------------------------------------------------------------- update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			issued_q      <= '0;
			used_q        <= '0;
			unused_q      <= '0;
		end else if (adv) begin
			if (set_en) begin
				entry_valid_q[free_idx] <= 1'b1;
			end
			if (clr_en) begin
				entry_valid_q[match_idx] <= 1'b0;
			end
			issued_q <= issued_nx;
			used_q   <= used_nx;
			unused_q <= unused_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && set_en) begin
			entry_addr_q[free_idx] <= line;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.issue_valid  <= set_en;
			rsp_q.issue_addr   <= set_en ? line : '0;
			rsp_q.outcome      <= outcome;
			rsp_q.issued_count <= issued_nx;
			rsp_q.used_count   <= used_nx;
			rsp_q.unused_count <= unused_nx;
		end
	end

	// ---------------------------------------------------------------- checks
	`PTT_ASSERT(a_issue_matches_outcome, rsp_valid_q |-> (rsp_q.issue_valid == (rsp_q.outcome == OUT_ISSUED)))
	`PTT_ASSERT(a_drop_only_when_full, ($past(adv) && rsp_q.outcome == OUT_DROPPED) |-> $past(&entry_valid_q))
	`PTT_ASSERT(a_issued_moves_with_item, (issued_q != $past(issued_q)) |-> ($past(adv) && rsp_q.outcome == OUT_ISSUED))
	`PTT_ASSERT_NEXT(a_one_entry_per_item, !adv, entry_valid_q == $past(entry_valid_q))

endmodule

`default_nettype wire

// ===== tb/tb_prefetch_tracking_table_core.sv =====
// Self-checking testbench for prefetch_tracking_table_core: directed script, then random phases
// at several line sizes, checked against an in-bench model; typed rows set their own outcome.
// Depends on ptt_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_prefetch_tracking_table_core;
	import ptt_pkg::*;

	localparam int          ENTRIES      = TABLE_ENTRIES_DEF;
	localparam int          POOL_LINES   = 20;     // a few more hot lines than table entries
	localparam int          DRAIN_CYCLES = 4;      // two-stage pipe plus margin
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          NUM_PHASES   = 10;
	// op 4 up to the top code are all "other access", ignored by the table
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		req_t              item;
		bit                typed;          // outcome/issue typed in below
		outcome_t          want_outcome;
		logic [ADDR_W-1:0] want_addr;
	} script_row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;

	prefetch_tracking_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// Table model: mirrors the block's state, updated per accepted item
	// ---------------------------------------------------------------
	logic [LSZ_W-1:0]  line_size_cfg = LSZ_RESET;
	bit                tracked_vld [ENTRIES];
	logic [ADDR_W-1:0] tracked_line[ENTRIES];
	logic [CNT_W-1:0]  n_issued = '0;
	logic [CNT_W-1:0]  n_used   = '0;
	logic [CNT_W-1:0]  n_unused = '0;

	rsp_t              pending_rsp[$];     // predicted results, oldest first
	logic [ADDR_W-1:0] line_pool[POOL_LINES];
	script_row_t       script[$];

	int unsigned       fail_count    = 0;
	int unsigned       items_sent    = 0;
	int unsigned       results_seen  = 0;
	int unsigned       cycle_count   = 0;
	int unsigned       outcome_tally[8];
	bit                idle_en       = 1'b1;
	int unsigned       stall_run     = 0;

	// out-of-range register values clamp to the legal line sizes
	function automatic int clamped_line_size();
		if (line_size_cfg < LSZ_MIN)
			return int'(LSZ_MIN);
		if (line_size_cfg > LSZ_MAX)
			return int'(LSZ_MAX);
		return int'(line_size_cfg);
	endfunction

	function automatic rsp_t track_step(input req_t item);
		rsp_t              res;
		logic [ADDR_W-1:0] line;
		int                hit_idx;
		int                free_idx;
		res      = '0;
		line     = item.addr & ~((48'd1 << clamped_line_size()) - 48'd1);
		hit_idx  = -1;
		free_idx = -1;
		// entry lines are only looked at while valid
		for (int i = 0; i < ENTRIES; i++) begin
			if (tracked_vld[i] && tracked_line[i] == line && hit_idx < 0)
				hit_idx = i;
			if (!tracked_vld[i] && free_idx < 0)
				free_idx = i;
		end
		res.outcome = OUT_NONE;
		case (item.op)
			OP_PREFETCH: begin
				if (hit_idx < 0) begin
					if (free_idx < 0) begin
						res.outcome = OUT_DROPPED;
					end else begin
						tracked_vld[free_idx]  = 1'b1;
						tracked_line[free_idx] = line;
						if (n_issued != '1)
							n_issued++;
						res.issue_valid = 1'b1;
						res.issue_addr  = line;
						res.outcome     = OUT_ISSUED;
					end
				end
			end
			OP_READ, OP_WRITE: begin
				if (hit_idx >= 0) begin
					tracked_vld[hit_idx] = 1'b0;
					if (item.hit) begin
						if (n_used != '1)
							n_used++;
						res.outcome = OUT_USED;
					end else begin
						res.outcome = OUT_LATE;
					end
				end
			end
			OP_EVICT: begin
				if (hit_idx >= 0) begin
					tracked_vld[hit_idx] = 1'b0;
					if (n_unused != '1)
						n_unused++;
					res.outcome = OUT_UNUSED;
				end
			end
			default: ;
		endcase
		res.issued_count = n_issued;
		res.used_count   = n_used;
		res.unused_count = n_unused;
		return res;
	endfunction

	// pf_pct: share of prefetch requests; the rest split over accesses, evictions, others
	function automatic req_t random_item(input int unsigned pf_pct);
		req_t              r;
		int unsigned       pick;
		logic [ADDR_W-1:0] off;
		pick  = $urandom_range(0, 99);
		r.hit = 1'($urandom_range(0, 1));
		if (pick < pf_pct)
			r.op = OP_PREFETCH;
		else if (pick < pf_pct + (90 - pf_pct) * 2 / 5)
			r.op = OP_READ;
		else if (pick < pf_pct + (90 - pf_pct) * 7 / 10)
			r.op = OP_WRITE;
		else if (pick < 90)
			r.op = OP_EVICT;
		else
			r.op = OP_W'($urandom_range(OP_OTHER, OP_SPARE_HI));
		// mostly hot lines with a random byte offset, some fully random noise
		if ($urandom_range(0, 9) == 0) begin
			r.addr = ADDR_W'({$urandom, $urandom});
		end else begin
			off    = ADDR_W'($urandom_range(0, (1 << clamped_line_size()) - 1));
			r.addr = line_pool[$urandom_range(0, POOL_LINES - 1)] | off;
		end
		return r;
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input bit hit, input bit typed, input outcome_t oc, input logic [ADDR_W-1:0] ia);
		script_row_t row;
		row.item.op      = op;
		row.item.addr    = addr;
		row.item.hit     = hit;
		row.typed        = typed;
		row.want_outcome = oc;
		row.want_addr    = ia;
		script.insert(script.size(), row);
	endfunction

	// ---------------------------------------------------------------
	// Request side: present one item, hold it until taken, maybe idle
	// Entered and left right after a rising edge.
	// ---------------------------------------------------------------
	task automatic send_item(input req_t item, input bit typed, input outcome_t want_oc,
			input logic [ADDR_W-1:0] want_addr);
		rsp_t predicted;
		req       <= item;
		req_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!req_stall)
				break;
		end
		predicted = track_step(item);
		if (typed) begin
			predicted.outcome     = want_oc;
			predicted.issue_valid = (want_oc == OUT_ISSUED);
			predicted.issue_addr  = want_addr;
		end
		pending_rsp.insert(pending_rsp.size(), predicted);
		outcome_tally[int'(predicted.outcome)]++;
		items_sent++;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// drop valid, wait out every outstanding result plus the pipe depth
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic write_line_size(input logic [LSZ_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(REG_LINE_SIZE) << 2;
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		line_size_cfg = value;
	endtask

	// Empty the table between phases. The line size goes to the minimum first,
	// so the lines still tracked are compared under a new alignment; every stored
	// line is aligned to at least the minimum, so an eviction of it matches.
	task automatic evict_all_tracked();
		logic [ADDR_W-1:0] lines[$];
		req_t              ev;
		wait_drained();
		write_line_size(LSZ_MIN);
		foreach (tracked_vld[i])
			if (tracked_vld[i])
				lines.insert(lines.size(), tracked_line[i]);
		foreach (lines[k]) begin
			ev.op   = OP_EVICT;
			ev.addr = lines[k];
			ev.hit  = 1'($urandom_range(0, 1));
			send_item(ev, 1'b0, OUT_NONE, '0);
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: random stall bursts, off in the closing phase
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_run != 0)
			stall_run--;
		else if (idle_en && $urandom_range(0, 5) == 0)
			stall_run = $urandom_range(1, 5);
		rsp_stall <= (stall_run != 0);
	end

	task automatic report_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		fail_count++;
	endtask

	// every taken result is checked field by field against the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with nothing expected, outcome %0d",
					$time, rsp.outcome);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.issue_valid !== want.issue_valid)
					report_mismatch("issue_valid", 64'(want.issue_valid),
						64'(rsp.issue_valid));
				if (rsp.issue_addr !== want.issue_addr)
					report_mismatch("issue_addr", 64'(want.issue_addr),
						64'(rsp.issue_addr));
				if (rsp.outcome !== want.outcome)
					report_mismatch("outcome", 64'(want.outcome), 64'(rsp.outcome));
				if (rsp.issued_count !== want.issued_count)
					report_mismatch("issued_count", 64'(want.issued_count),
						64'(rsp.issued_count));
				if (rsp.used_count !== want.used_count)
					report_mismatch("used_count", 64'(want.used_count),
						64'(rsp.used_count));
				if (rsp.unused_count !== want.unused_count)
					report_mismatch("unused_count", 64'(want.unused_count),
						64'(rsp.unused_count));
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		// line size per phase: both ends, out-of-range values on each side, a few inside
		int unsigned phase_lsz[NUM_PHASES] = '{2, 12, 0, 15, 1, 13, 4, 9, 7, 6};
		// prefetch share: the heavy phases keep the table near full so drops occur
		int unsigned phase_pf [NUM_PHASES] = '{45, 45, 70, 45, 45, 70, 45, 55, 45, 50};
		int unsigned phase_len[NUM_PHASES] = '{100, 100, 100, 100, 90, 100, 100, 100, 100, 100};

		foreach (tracked_vld[i])
			tracked_vld[i] = 1'b0;
		foreach (outcome_tally[i])
			outcome_tally[i] = 0;
		// hot lines aligned to the largest line size, so any offset stays inside
		foreach (line_pool[k])
			line_pool[k] = (ADDR_W'({$urandom, $urandom}) >> LSZ_MAX) << LSZ_MAX;

		// Directed script, reset line size of 64 bytes.
		// lowest and highest address, re-request of a tracked line
		add_row(OP_PREFETCH, 48'h0,              1'b0, 1'b1, OUT_ISSUED, 48'h0);
		add_row(OP_PREFETCH, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, OUT_ISSUED, 48'hFFFF_FFFF_FFC0);
		add_row(OP_PREFETCH, 48'h3F,             1'b1, 1'b1, OUT_NONE,   48'h0);
		// read hit uses it, repeat finds nothing, write miss is late
		add_row(OP_READ,     48'h10,             1'b1, 1'b1, OUT_USED,   48'h0);
		add_row(OP_READ,     48'h10,             1'b1, 1'b1, OUT_NONE,   48'h0);
		add_row(OP_WRITE,    48'hFFFF_FFFF_FFC5, 1'b0, 1'b1, OUT_LATE,   48'h0);
		// other ops leave a tracked line alone; eviction ignores the hit bit
		add_row(OP_PREFETCH, 48'h1000,           1'b0, 1'b1, OUT_ISSUED, 48'h1000);
		add_row(OP_OTHER,    48'h1000,           1'b1, 1'b1, OUT_NONE,   48'h0);
		add_row(OP_SPARE_HI, 48'h1000,           1'b0, 1'b1, OUT_NONE,   48'h0);
		add_row(OP_EVICT,    48'h103C,           1'b1, 1'b1, OUT_UNUSED, 48'h0);
		add_row(OP_EVICT,    48'h1000,           1'b0, 1'b1, OUT_NONE,   48'h0);
		// fill every entry, then one more is dropped
		for (int i = 0; i < ENTRIES; i++)
			add_row(OP_PREFETCH, 48'h10000 + (48'(i) << 12) + 48'(i), 1'b0, 1'b1,
				OUT_ISSUED, 48'h10000 + (48'(i) << 12));
		add_row(OP_PREFETCH, 48'h20000,          1'b0, 1'b1, OUT_DROPPED, 48'h0);
		add_row(OP_PREFETCH, 48'h1303F,          1'b1, 1'b1, OUT_NONE,    48'h0);
		// free one entry and reuse it
		add_row(OP_READ,     48'h13020,          1'b1, 1'b1, OUT_USED,    48'h0);
		add_row(OP_PREFETCH, 48'h20000,          1'b0, 1'b1, OUT_ISSUED,  48'h20000);
		add_row(OP_WRITE,    48'h15001,          1'b1, 1'b0, OUT_NONE,    48'h0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[n])
			send_item(script[n].item, script[n].typed, script[n].want_outcome,
				script[n].want_addr);

		for (int p = 0; p < NUM_PHASES; p++) begin
			evict_all_tracked();
			wait_drained();
			// closing phase runs at full rate on both sides
			if (p == NUM_PHASES - 1)
				idle_en = 1'b0;
			write_line_size(LSZ_W'(phase_lsz[p]));
			repeat (phase_len[p])
				send_item(random_item(phase_pf[p]), 1'b0, OUT_NONE, '0);
		end

		wait_drained();
		if (pending_rsp.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_rsp.size());
			fail_count++;
		end

		$display("Ran %0d items over %0d line-size settings, %0d results checked.",
			items_sent, NUM_PHASES + 1, results_seen);
		$display("Outcomes: none %0d issued %0d used %0d late %0d unused %0d dropped %0d",
			outcome_tally[OUT_NONE], outcome_tally[OUT_ISSUED], outcome_tally[OUT_USED],
			outcome_tally[OUT_LATE], outcome_tally[OUT_UNUSED], outcome_tally[OUT_DROPPED]);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
